// ===== sv/wam_pkg.sv =====
// ----------------------------------------------------------------------------
// wam_pkg
// Shared types and constants for the weekly alarm matcher.
// ----------------------------------------------------------------------------
package wam_pkg;

    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int WEEKDAY_W  = 3;
    localparam int MASK_W     = 7;
    localparam int SLOT_W     = 19;
    localparam int SLOT_IDX_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    // minute mark that no real tick carries after reset
    localparam logic [MINUTE_W-1:0] NEVER_FIRED = 6'd61;
    localparam logic [WEEKDAY_W-1:0] DAYS_PER_WEEK = 3'd7;

    // alarm slot register layout, lowest field last
    typedef struct packed {
        logic                enable;
        logic [MASK_W-1:0]   mask;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
    } slot_t;

    typedef struct packed {
        logic [WEEKDAY_W-1:0] weekday;
        logic [MINUTE_W-1:0]  minute;
        logic [HOUR_W-1:0]    hour;
    } tick_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] fired_slot;
        logic                  alarm_fired;
    } result_t;

    // request from the match stage to mark a one-shot slot spent
    typedef struct packed {
        logic                  vld;
        logic [SLOT_IDX_W-1:0] idx;
    } spend_req_t;

endpackage

// ===== sv/wam_slot_cmp.sv =====
// ----------------------------------------------------------------------------
// wam_slot_cmp
// Compares one alarm slot against the current tick.
// ----------------------------------------------------------------------------
module wam_slot_cmp (
    input  wam_pkg::slot_t slot,
    input  logic           spent,
    input  wam_pkg::tick_t tick,
    output logic           hit,
    output logic           one_shot
);
    import wam_pkg::*;

    logic [MASK_W:0] mask_ext;
    logic            today;
    logic            time_eq;

    // weekday seven lands on the zero pad bit
    assign mask_ext = {1'b0, slot.mask};
    assign today    = (tick.weekday < DAYS_PER_WEEK) && mask_ext[tick.weekday];
    assign one_shot = (slot.mask == '0);
    assign time_eq  = (slot.hour == tick.hour) && (slot.minute == tick.minute);
    assign hit      = slot.enable && !spent && time_eq && (one_shot || today);

endmodule

// ===== sv/wam_apb_regs.sv =====
// ----------------------------------------------------------------------------
// wam_apb_regs
// Alarm slot registers on the APB port, with the per-slot spent flags.
// ----------------------------------------------------------------------------
module wam_apb_regs #(
    parameter int NUM_SLOTS = 5,
    parameter int IDX_W     = 3
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [IDX_W+1:0]                     paddr,
    input  logic [wam_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [wam_pkg::APB_DATA_W-1:0]       prdata,
    input  wam_pkg::spend_req_t                  spend,
    output wam_pkg::slot_t [NUM_SLOTS-1:0]       slots,
    output logic [NUM_SLOTS-1:0]                 spent
);
    import wam_pkg::*;

    slot_t [NUM_SLOTS-1:0] slot_reg;
    logic  [NUM_SLOTS-1:0] spent_reg;
    logic  [IDX_W-1:0]     reg_idx;
    logic                  idx_ok;
    logic                  wr_en;

    assign reg_idx = paddr[IDX_W+1:2];
    assign idx_ok  = (int'(reg_idx) < NUM_SLOTS);
    assign wr_en   = psel && penable && pwrite && idx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= '0;
            spent_reg <= '0;
        end else begin
            if (wr_en) begin
                slot_reg[reg_idx]  <= pwdata[SLOT_W-1:0];
                spent_reg[reg_idx] <= 1'b0;
            end
            if (spend.vld) begin
                spent_reg[spend.idx[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (idx_ok) begin
            prdata = {{(APB_DATA_W-SLOT_W){1'b0}}, slot_reg[reg_idx]};
        end
    end

    assign slots = slot_reg;
    assign spent = spent_reg;

endmodule

// ===== sv/weekly_alarm_matcher_top.sv =====
// ----------------------------------------------------------------------------
// weekly_alarm_matcher_top
// Weekly alarm comparator: each tick is matched against all alarm slots.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  s_      | in  | tick beat: hour, minute, weekday
//  m_      | out | result beat: alarm_fired, fired_slot
//  apb     | in  | alarm slot registers at 4*i
//
//  one beat per cycle sustained while m_tready is high; path is the input
//  register, then slot compare and priority pick into the result register
//  spent flags and last fired minute update at the result register load,
//  so the next tick already sees them
//  reset is synchronous; no clearing pass
//  m_tready low holds the result and stalls the input register behind it
// ----------------------------------------------------------------------------
module weekly_alarm_matcher_top #(
    parameter int NUM_SLOTS = 5
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // [4:0] now_hour, [10:5] now_minute, [13:11] now_weekday
    input  logic [wam_pkg::S_TDATA_W-1:0]               s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // [0] alarm_fired, [3:1] fired_slot
    output logic [wam_pkg::M_TDATA_W-1:0]               m_tdata,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)+1:0] paddr,
    input  logic [wam_pkg::APB_DATA_W-1:0]              pwdata,
    output logic [wam_pkg::APB_DATA_W-1:0]              prdata,
    output logic                                        pready
);
    import wam_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    tick_t                 tick_reg;
    logic                  in_valid_reg;
    result_t               res_reg;
    result_t               res_next;
    logic                  out_valid_reg;
    logic [MINUTE_W-1:0]   last_min_reg;
    logic                  advance;
    logic                  out_free;

    slot_t [NUM_SLOTS-1:0] slots;
    logic  [NUM_SLOTS-1:0] spent;
    logic  [NUM_SLOTS-1:0] hit;
    logic  [NUM_SLOTS-1:0] one_shot;
    logic                  fire_any;
    logic [SLOT_IDX_W-1:0] win_idx;
    logic                  win_one_shot;
    spend_req_t            spend;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg <= s_tdata[HOUR_W+MINUTE_W+WEEKDAY_W-1:0];
        end
    end

    wam_apb_regs #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .spend   (spend),
        .slots   (slots),
        .spent   (spent)
    );

    assign pready = 1'b1;

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_lane
        wam_slot_cmp u_cmp (
            .slot     (slots[i]),
            .spent    (spent[i]),
            .tick     (tick_reg),
            .hit      (hit[i]),
            .one_shot (one_shot[i])
        );
    end

    // lowest slot wins: walk from the top so lower indexes overwrite
    always_comb begin
        fire_any     = 1'b0;
        win_idx      = '0;
        win_one_shot = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                fire_any     = 1'b1;
                win_idx      = SLOT_IDX_W'(i);
                win_one_shot = one_shot[i];
            end
        end
        // same minute as the last firing suppresses everything
        if (tick_reg.minute == last_min_reg) begin
            fire_any = 1'b0;
            win_idx  = '0;
        end
    end

    assign res_next.alarm_fired = fire_any;
    assign res_next.fired_slot  = win_idx;

    assign spend.vld = advance && fire_any && win_one_shot;
    assign spend.idx = win_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            last_min_reg  <= NEVER_FIRED;
        end else begin
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && fire_any) begin
                last_min_reg <= tick_reg.minute;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-SLOT_IDX_W-1){1'b0}}, res_reg};

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.alarm_fired) |-> (int'(res_reg.fired_slot) < NUM_SLOTS))
        else $error("fired slot index beyond configured slots");

    a_idle_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !res_reg.alarm_fired) |-> (res_reg.fired_slot == '0))
        else $error("slot index nonzero without a firing");

    a_mark_follows_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && fire_any) |=> (last_min_reg == $past(tick_reg.minute)))
        else $error("last fired minute not updated on a firing");

    a_mark_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && fire_any) |=> $stable(last_min_reg))
        else $error("last fired minute changed without a firing");
`endif

endmodule
